FILE: src/mlsg_pkg.sv
// Package for the motion limit sensor guard: word types, register codes,
// widths and reset constants. Used by every module of the block.
package mlsg_pkg;

  // Fixed field widths
  localparam int SENSOR_W   = 4;
  localparam int TIME_W     = 16;
  localparam int TOTAL_W    = 32;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  // Defaults for the top-level parameters
  localparam int NUM_POLLED_DEF = 4;
  localparam int COUNT_BITS_DEF = 16;

  // Register reset values
  localparam logic [TIME_W-1:0]     THRESH_RESET    = 16'd4;
  localparam logic [TIME_W-1:0]     ARM_DELAY_RESET = 16'd200;
  localparam logic [SENSOR_W-1:0]   POLARITY_RESET  = '0;
  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RESET  = '0;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STALL_HIT_THRESHOLD = 2'd0,
    REG_STALL_ARM_DELAY     = 2'd1,
    REG_POLARITY_MASK       = 2'd2,
    REG_DEBOUNCE_TIMES      = 2'd3
  } mlsg_reg_t;

  // One tick word in
  typedef struct packed {
    logic [SENSOR_W-1:0] sensor_levels;
    logic                estop_edge;
    logic                crash_edge;
    logic                stall_edge;
    logic                motion_start;
    logic                motion_end;
    logic                consume_estop;
    logic                consume_crash;
    logic                consume_stall;
  } mlsg_in_t;

  // One result word out
  typedef struct packed {
    logic [SENSOR_W-1:0] stable_active;
    logic                halt_estop;
    logic                halt_crash;
    logic                halt_stall;
    logic                estop_latched;
    logic                crash_latched;
    logic                stall_latched;
    logic                stall_armed;
    logic [TIME_W-1:0]   stall_hit_count;
    logic [TOTAL_W-1:0]  stall_hits_total;
  } mlsg_out_t;

  // Fault and stall status handed from the stall unit to the top level
  typedef struct packed {
    logic               halt_estop;
    logic               halt_crash;
    logic               halt_stall;
    logic               estop_latched;
    logic               crash_latched;
    logic               stall_latched;
    logic               stall_armed;
    logic [TIME_W-1:0]  hit_count;
    logic [TOTAL_W-1:0] hits_total;
  } mlsg_stall_stat_t;

endpackage

FILE: src/motion_limit_sensor_guard_core.sv
// Top level of the motion limit sensor guard: configuration registers,
// tick handshake and result register. Uses mlsg_pkg, mlsg_debounce, mlsg_stall.
//
// Usage: send one word on in_word per millisecond tick (in_valid/in_ready).
// Each accepted tick yields exactly one result word on out_word
// (out_valid/out_ready): debounced limit states, halt pulses, fault latches,
// stall arm state and stall counters.
// Latency: the result of a tick is valid in the cycle after it is accepted.
// Throughput: one tick per cycle while out_ready is high; all work is a single pass of counters and
// compares between the tick input and the result register.
// Stall: while a result waits, in_ready stays high only if out_ready is high
// in the same cycle, so a held result is never overwritten or dropped.
// Configuration: cfg_we writes cfg_data into the register at cfg_index;
// write only while no tick is in flight.
// Reset (rst, synchronous): clears all debounce, stall and latch state, drops
// any pending result and loads the register defaults (threshold 4, arm delay
// 200, polarity 0, debounce times 0). No clearing pass is needed.
module motion_limit_sensor_guard_core
  import mlsg_pkg::*;
#(
  parameter int NUM_POLLED = NUM_POLLED_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mlsg_in_t              in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mlsg_out_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [TIME_W-1:0]     threshold;
  logic [TIME_W-1:0]     arm_delay;
  logic [SENSOR_W-1:0]   polarity;
  logic [CFG_DATA_W-1:0] deb_times;
  logic                  step;
  logic [SENSOR_W-1:0]   stable_active;
  mlsg_stall_stat_t      stat;

  // Load configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
      arm_delay <= ARM_DELAY_RESET;
      polarity  <= POLARITY_RESET;
      deb_times <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STALL_HIT_THRESHOLD: threshold <= cfg_data[TIME_W-1:0];
        REG_STALL_ARM_DELAY:     arm_delay <= cfg_data[TIME_W-1:0];
        REG_POLARITY_MASK:       polarity  <= cfg_data[SENSOR_W-1:0];
        REG_DEBOUNCE_TIMES:      deb_times <= cfg_data;
        default:                 threshold <= threshold;
      endcase
    end
  end

  // Accept a tick whenever the result register is free or being drained
  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  mlsg_debounce #(
    .NUM_POLLED (NUM_POLLED),
    .COUNT_BITS (COUNT_BITS)
  ) u_debounce (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .levels        (in_word.sensor_levels),
    .polarity      (polarity),
    .deb_times     (deb_times),
    .stable_active (stable_active)
  );

  mlsg_stall #(
    .COUNT_BITS (COUNT_BITS)
  ) u_stall (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .tick      (in_word),
    .threshold (threshold),
    .arm_delay (arm_delay),
    .stat      (stat)
  );

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word.stable_active    <= stable_active;
      out_word.halt_estop       <= stat.halt_estop;
      out_word.halt_crash       <= stat.halt_crash;
      out_word.halt_stall       <= stat.halt_stall;
      out_word.estop_latched    <= stat.estop_latched;
      out_word.crash_latched    <= stat.crash_latched;
      out_word.stall_latched    <= stat.stall_latched;
      out_word.stall_armed      <= stat.stall_armed;
      out_word.stall_hit_count  <= stat.hit_count;
      out_word.stall_hits_total <= stat.hits_total;
    end
  end

`ifndef NO_ASSERTIONS
  a_tick_gives_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted tick produced no result word");

  a_stall_halt_latched: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.halt_stall |-> out_word.stall_latched && out_word.stall_armed)
    else $error("stall halt without latch or arm");

  a_stall_halt_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.halt_stall |-> out_word.stall_hit_count == '0)
    else $error("stall halt left pending hits");

  a_estop_halt_latched: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.halt_estop |-> out_word.estop_latched)
    else $error("estop halt without latch");
`endif

endmodule

FILE: src/mlsg_debounce.sv
// Polarity correction and per-input debounce of the polled limit inputs.
// Depends on mlsg_pkg for widths.
module mlsg_debounce
  import mlsg_pkg::*;
#(
  parameter int NUM_POLLED = NUM_POLLED_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [SENSOR_W-1:0]   levels,
  input  logic [SENSOR_W-1:0]   polarity,
  input  logic [CFG_DATA_W-1:0] deb_times,
  output logic [SENSOR_W-1:0]   stable_active
);

  localparam logic [COUNT_BITS-1:0] CntMax = {COUNT_BITS{1'b1}};

  logic [NUM_POLLED-1:0] cand;
  logic [NUM_POLLED-1:0] cand_next;
  logic [NUM_POLLED-1:0] stable;
  logic [NUM_POLLED-1:0] stable_next;
  logic [COUNT_BITS-1:0] elapsed      [NUM_POLLED];
  logic [COUNT_BITS-1:0] elapsed_next [NUM_POLLED];

  for (genvar g = 0; g < NUM_POLLED; g++) begin : g_lane
    logic              active;
    logic [TIME_W-1:0] deb;

    assign active = levels[g] ^ polarity[g];
    assign deb    = deb_times[g*TIME_W +: TIME_W];

    // Restart on a new candidate, else count and promote once held long enough
    always_comb begin
      cand_next[g]    = cand[g];
      stable_next[g]  = stable[g];
      elapsed_next[g] = elapsed[g];
      if (active != cand[g]) begin
        cand_next[g]    = active;
        elapsed_next[g] = '0;
      end else begin
        elapsed_next[g] = (elapsed[g] == CntMax) ? CntMax : elapsed[g] + 1'b1;
        if ((active != stable[g]) && (TIME_W'(elapsed_next[g]) >= deb)) begin
          stable_next[g] = active;
        end
      end
    end

    // Advance the lane on each accepted tick
    always_ff @(posedge clk) begin
      if (rst) begin
        cand[g]    <= 1'b0;
        stable[g]  <= 1'b0;
        elapsed[g] <= '0;
      end else if (step) begin
        cand[g]    <= cand_next[g];
        stable[g]  <= stable_next[g];
        elapsed[g] <= elapsed_next[g];
      end
    end
  end

  // Unused inputs read as inactive
  assign stable_active = SENSOR_W'(stable_next);

endmodule

FILE: src/mlsg_stall.sv
// Fault latches, halt requests, stall arm window and stall hit counters.
// Depends on mlsg_pkg for widths and the status struct.
module mlsg_stall
  import mlsg_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  mlsg_in_t          tick,
  input  logic [TIME_W-1:0] threshold,
  input  logic [TIME_W-1:0] arm_delay,
  output mlsg_stall_stat_t  stat
);

  localparam logic [COUNT_BITS-1:0] CntMax = {COUNT_BITS{1'b1}};

  logic                  armed;
  logic                  armed_next;
  logic [COUNT_BITS-1:0] arm_el;
  logic [COUNT_BITS-1:0] arm_el_next;
  logic [COUNT_BITS-1:0] pend;
  logic [COUNT_BITS-1:0] pend_next;
  logic [TOTAL_W-1:0]    total;
  logic [TOTAL_W-1:0]    total_next;
  logic                  lat_e;
  logic                  lat_c;
  logic                  lat_s;
  logic                  shown_e;
  logic                  shown_c;
  logic                  shown_s;
  logic                  halt_s;
  logic                  past_delay;

  // Motion end, then start, then arm time
  always_comb begin
    armed_next  = armed && !tick.motion_end;
    arm_el_next = arm_el;
    if (tick.motion_start) begin
      armed_next  = 1'b1;
      arm_el_next = '0;
    end else if (armed_next) begin
      arm_el_next = (arm_el == CntMax) ? CntMax : arm_el + 1'b1;
    end
  end

  assign past_delay = armed_next && (TIME_W'(arm_el_next) >= arm_delay);

  // Count stall edges, halt at threshold, then drop hits outside the window
  always_comb begin
    logic [COUNT_BITS-1:0] pend_base;
    pend_base  = tick.motion_start ? '0 : pend;
    pend_next  = pend_base;
    total_next = total;
    halt_s     = 1'b0;
    if (tick.stall_edge) begin
      pend_next  = (pend_base == CntMax) ? CntMax : pend_base + 1'b1;
      total_next = total + 1'b1;
      if (past_delay && !lat_s && (TIME_W'(pend_next) >= threshold)) begin
        halt_s    = 1'b1;
        pend_next = '0;
      end
    end
    if (!past_delay) begin
      pend_next = '0;
    end
  end

  // Latch state shown in this tick's word, before consumes
  assign shown_e = lat_e || tick.estop_edge;
  assign shown_c = lat_c || tick.crash_edge;
  assign shown_s = lat_s || halt_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      armed  <= 1'b0;
      arm_el <= '0;
      pend   <= '0;
      total  <= '0;
      lat_e  <= 1'b0;
      lat_c  <= 1'b0;
      lat_s  <= 1'b0;
    end else if (step) begin
      armed  <= armed_next;
      arm_el <= arm_el_next;
      pend   <= pend_next;
      total  <= total_next;
      lat_e  <= shown_e && !tick.consume_estop;
      lat_c  <= shown_c && !tick.consume_crash;
      lat_s  <= shown_s && !tick.consume_stall;
    end
  end

  always_comb begin
    stat.halt_estop    = tick.estop_edge;
    stat.halt_crash    = tick.crash_edge;
    stat.halt_stall    = halt_s;
    stat.estop_latched = shown_e;
    stat.crash_latched = shown_c;
    stat.stall_latched = shown_s;
    stat.stall_armed   = armed_next;
    stat.hit_count     = TIME_W'(pend_next);
    stat.hits_total    = total_next;
  end

endmodule
